FILE: rtl/scfl_pkg.sv
// Shared types and constants of the size-class free-list allocator.
`default_nettype none
package scfl_pkg;

    localparam int unsigned OFF_W = 16;
    localparam int unsigned SUM_W = 18;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED   = 3'd2;
    localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
    localparam logic [2:0] ST_BAD_POINTER = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic             func;
        logic [OFF_W-1:0] alloc_size;
        logic [OFF_W-1:0] pointer_in;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0] pointer_out;
        logic [2:0]       status;
    } t_result;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] limit;
    } t_alu_op;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             gt;
    } t_alu_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CLS,
        S_A_HEAD,
        S_A_HDR,
        S_A_LINK,
        S_F_CHK,
        S_F_HDR,
        S_F_HEAD,
        S_F_MARK
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/size_class_free_list_allocator_unit.sv
// Top level of the size-class free-list allocator.
// A request word is taken at a clock edge where start is high and busy is low; busy then
// stays high while the sequencer walks its states; an oversized allocate ends in S_A_CLS,
// a bump one in S_A_HEAD, a list pop in S_A_LINK, a free in S_F_CHK, S_F_HDR or S_F_MARK.
// The steps are set by the single-port heap word RAM: header read, link read or write and
// header update go through it one after another, under one sequencer with one shared
// adder/compare. The result word shows on o_result for one cycle with o_valid high, in
// the cycle busy falls, and a new start may be taken in that same cycle. There is no
// result backpressure. Class list heads are empty right after reset (per-class valid
// bits), so no clearing pass is needed; heap words hold nothing defined until written.
`default_nettype none
module size_class_free_list_allocator_unit #(
    parameter int unsigned HEAP_BYTES   = 65536,
    parameter int unsigned NUM_CLASSES  = 63,
    parameter int unsigned HEADER_BYTES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire scfl_pkg::t_req     i_req,
    output logic                    o_valid,
    output scfl_pkg::t_result       o_result
);
    localparam int unsigned SLOTS = HEAP_BYTES / 8;
    localparam int unsigned SW    = $clog2(SLOTS);
    localparam int unsigned CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    scfl_pkg::t_alu_op  alu_op;
    scfl_pkg::t_alu_res alu_res;
    logic               heap_we;
    logic [SW-1:0]      heap_addr;
    logic [15:0]        heap_wdata;
    logic [15:0]        heap_rdata;
    logic               head_we;
    logic [CW-1:0]      head_addr;
    logic [15:0]        head_wdata;
    logic [15:0]        head_rdata;

    scfl_ctrl #(
        .HEAP_BYTES   (HEAP_BYTES),
        .NUM_CLASSES  (NUM_CLASSES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_req        (i_req),
        .o_valid      (o_valid),
        .o_result     (o_result),
        .o_alu        (alu_op),
        .i_alu        (alu_res),
        .o_heap_we    (heap_we),
        .o_heap_addr  (heap_addr),
        .o_heap_wdata (heap_wdata),
        .i_heap_rdata (heap_rdata),
        .o_head_we    (head_we),
        .o_head_addr  (head_addr),
        .o_head_wdata (head_wdata),
        .i_head_rdata (head_rdata)
    );

    scfl_alu u_alu (
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    scfl_ram #(
        .DW    (16),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_addr  (heap_addr),
        .i_wdata (heap_wdata),
        .o_rdata (heap_rdata)
    );

    scfl_ram #(
        .DW    (16),
        .DEPTH (NUM_CLASSES),
        .AW    (CW)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_addr  (head_addr),
        .i_wdata (head_wdata),
        .o_rdata (head_rdata)
    );
endmodule
`default_nettype wire

FILE: rtl/scfl_ram.sv
// Single-port RAM with registered read data.
`default_nettype none
module scfl_ram #(
    parameter int unsigned DW    = 16,
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/scfl_alu.sv
// Shared adder and limit compare used by the bump, pointer and header checks of the sequencer.
`default_nettype none
module scfl_alu (
    input  wire scfl_pkg::t_alu_op  i_op,
    output scfl_pkg::t_alu_res      o_res
);
    logic [scfl_pkg::SUM_W-1:0] sum;

    assign sum       = i_op.a + i_op.b;
    assign o_res.sum = sum;
    assign o_res.gt  = sum > i_op.limit;
endmodule
`default_nettype wire

FILE: rtl/scfl_ctrl.sv
// Sequencer: request decode, list pop/push, bump allocation, status.
`default_nettype none
module scfl_ctrl #(
    parameter int unsigned HEAP_BYTES   = 65536,
    parameter int unsigned NUM_CLASSES  = 63,
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned SLOTS        = HEAP_BYTES / 8,
    parameter int unsigned SW           = $clog2(SLOTS),
    parameter int unsigned CW           = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
    parameter int unsigned BW           = $clog2(HEAP_BYTES + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire scfl_pkg::t_req      i_req,
    output logic                     o_valid,
    output scfl_pkg::t_result        o_result,
    output scfl_pkg::t_alu_op        o_alu,
    input  wire scfl_pkg::t_alu_res  i_alu,
    output logic                     o_heap_we,
    output logic [SW-1:0]            o_heap_addr,
    output logic [15:0]              o_heap_wdata,
    input  wire logic [15:0]         i_heap_rdata,
    output logic                     o_head_we,
    output logic [CW-1:0]            o_head_addr,
    output logic [15:0]              o_head_wdata,
    input  wire logic [15:0]         i_head_rdata
);
    localparam int unsigned SUM_W = scfl_pkg::SUM_W;

    scfl_pkg::t_state  r_state, n_state;
    scfl_pkg::t_req    r_req, n_req;
    scfl_pkg::t_result r_result, n_result;
    logic              r_valid, n_valid;
    logic [CW-1:0]     r_cls, n_cls;
    logic [15:0]       r_head, n_head;
    logic [15:0]       r_hdr, n_hdr;
    logic [BW-1:0]     r_bump, n_bump;
    logic [NUM_CLASSES-1:0] r_head_vld, n_head_vld;

    logic [13:0] k_raw, k;
    logic        too_large;
    logic [15:0] head_q;
    logic [15:0] h_off;
    logic        hdr_bad;
    logic        ptr_bad;

    assign k_raw     = 14'((17'(r_req.alloc_size) + 17'd7) >> 3);
    assign k         = (k_raw == 14'd0) ? 14'd1 : k_raw;
    assign too_large = k > 14'(NUM_CLASSES);
    assign head_q    = r_head_vld[r_cls] ? i_head_rdata : 16'd0;
    assign h_off     = r_req.pointer_in - 16'd8;
    assign ptr_bad   = (r_req.pointer_in[2:0] != 3'd0) ||
                       (17'(r_req.pointer_in) < 17'(HEADER_BYTES + 8)) || i_alu.gt;
    assign hdr_bad   = (i_heap_rdata == 16'd0) || (i_heap_rdata[2:0] != 3'd0) ||
                       (i_heap_rdata[15:3] > 13'(NUM_CLASSES)) || i_alu.gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= scfl_pkg::S_IDLE;
            r_valid    <= 1'b0;
            r_bump     <= BW'(HEADER_BYTES);
            r_head_vld <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_bump     <= n_bump;
            r_head_vld <= n_head_vld;
        end
        r_req    <= n_req;
        r_result <= n_result;
        r_cls    <= n_cls;
        r_head   <= n_head;
        r_hdr    <= n_hdr;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            scfl_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_req.func == scfl_pkg::FUNC_FREE) ? scfl_pkg::S_F_CHK
                                                                  : scfl_pkg::S_A_CLS;
                end
            end
            scfl_pkg::S_A_CLS:  n_state = too_large ? scfl_pkg::S_IDLE : scfl_pkg::S_A_HEAD;
            scfl_pkg::S_A_HEAD: n_state = (head_q != 16'd0) ? scfl_pkg::S_A_HDR
                                                            : scfl_pkg::S_IDLE;
            scfl_pkg::S_A_HDR:  n_state = scfl_pkg::S_A_LINK;
            scfl_pkg::S_A_LINK: n_state = scfl_pkg::S_IDLE;
            scfl_pkg::S_F_CHK:  n_state = ptr_bad ? scfl_pkg::S_IDLE : scfl_pkg::S_F_HDR;
            scfl_pkg::S_F_HDR: begin
                n_state = (i_heap_rdata[0] || hdr_bad) ? scfl_pkg::S_IDLE
                                                       : scfl_pkg::S_F_HEAD;
            end
            scfl_pkg::S_F_HEAD: n_state = scfl_pkg::S_F_MARK;
            scfl_pkg::S_F_MARK: n_state = scfl_pkg::S_IDLE;
            default:            n_state = scfl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_req        = r_req;
        n_result     = r_result;
        n_valid      = 1'b0;
        n_cls        = r_cls;
        n_head       = r_head;
        n_hdr        = r_hdr;
        n_bump       = r_bump;
        n_head_vld   = r_head_vld;
        o_alu        = '0;
        o_heap_we    = 1'b0;
        o_heap_addr  = '0;
        o_heap_wdata = '0;
        o_head_we    = 1'b0;
        o_head_addr  = r_cls;
        o_head_wdata = '0;
        case (r_state)
            scfl_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                end
            end
            scfl_pkg::S_A_CLS: begin
                o_head_addr = CW'(k - 14'd1);
                n_cls       = CW'(k - 14'd1);
                if (too_large) begin
                    n_valid  = 1'b1;
                    n_result = '{pointer_out: 16'd0, status: scfl_pkg::ST_TOO_LARGE};
                end
            end
            scfl_pkg::S_A_HEAD: begin
                o_alu.a     = SUM_W'(r_bump);
                o_alu.b     = SUM_W'({k + 14'd1, 3'b000});
                o_alu.limit = SUM_W'(HEAP_BYTES);
                n_head      = head_q;
                if (head_q != 16'd0) begin
                    o_heap_addr = head_q[SW+2:3];
                end else begin
                    n_valid = 1'b1;
                    if (i_alu.gt) begin
                        n_result = '{pointer_out: 16'd0, status: scfl_pkg::ST_EXHAUSTED};
                    end else begin
                        o_heap_we    = 1'b1;
                        o_heap_addr  = r_bump[SW+2:3];
                        o_heap_wdata = 16'({k, 3'b000});
                        n_result     = '{pointer_out: 16'(SUM_W'(r_bump) + SUM_W'(8)),
                                         status: scfl_pkg::ST_OK};
                        n_bump       = BW'(i_alu.sum);
                    end
                end
            end
            scfl_pkg::S_A_HDR: begin
                n_hdr       = i_heap_rdata;
                o_heap_addr = SW'(r_head[15:3] + 13'd1);
            end
            scfl_pkg::S_A_LINK: begin
                o_head_we         = 1'b1;
                o_head_wdata      = i_heap_rdata;
                n_head_vld[r_cls] = 1'b1;
                o_heap_we         = 1'b1;
                o_heap_addr       = r_head[SW+2:3];
                o_heap_wdata      = r_hdr & 16'hFFFE;
                n_valid           = 1'b1;
                n_result          = '{pointer_out: r_head + 16'd8, status: scfl_pkg::ST_OK};
            end
            scfl_pkg::S_F_CHK: begin
                o_alu.a     = SUM_W'(r_req.pointer_in);
                o_alu.b     = SUM_W'(1);
                o_alu.limit = SUM_W'(r_bump);
                o_heap_addr = h_off[SW+2:3];
                if (ptr_bad) begin
                    n_valid  = 1'b1;
                    n_result = '{pointer_out: 16'd0, status: scfl_pkg::ST_BAD_POINTER};
                end
            end
            scfl_pkg::S_F_HDR: begin
                o_alu.a     = SUM_W'(r_req.pointer_in);
                o_alu.b     = SUM_W'(i_heap_rdata);
                o_alu.limit = SUM_W'(r_bump);
                n_hdr       = i_heap_rdata;
                o_head_addr = CW'(i_heap_rdata[15:3] - 13'd1);
                n_cls       = CW'(i_heap_rdata[15:3] - 13'd1);
                if (i_heap_rdata[0]) begin
                    n_valid  = 1'b1;
                    n_result = '{pointer_out: 16'd0, status: scfl_pkg::ST_DOUBLE_FREE};
                end else if (hdr_bad) begin
                    n_valid  = 1'b1;
                    n_result = '{pointer_out: 16'd0, status: scfl_pkg::ST_BAD_POINTER};
                end
            end
            scfl_pkg::S_F_HEAD: begin
                o_heap_we    = 1'b1;
                o_heap_addr  = r_req.pointer_in[SW+2:3];
                o_heap_wdata = head_q;
            end
            scfl_pkg::S_F_MARK: begin
                o_heap_we         = 1'b1;
                o_heap_addr       = h_off[SW+2:3];
                o_heap_wdata      = r_hdr | 16'h0001;
                o_head_we         = 1'b1;
                o_head_wdata      = h_off;
                n_head_vld[r_cls] = 1'b1;
                n_valid           = 1'b1;
                n_result          = '{pointer_out: 16'd0, status: scfl_pkg::ST_OK};
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    assign o_busy   = r_state != scfl_pkg::S_IDLE;
    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule
`default_nettype wire

FILE: rtl/scfl_chk.sv
// Port-level checker for the allocator and its bind to the top level.
`default_nettype none
module scfl_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire scfl_pkg::t_result  o_result
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status != scfl_pkg::ST_OK) |-> o_result.pointer_out == 16'd0)
        else $error("nonzero pointer on failed request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.status <= scfl_pkg::ST_BAD_POINTER)
        else $error("undefined status code");
endmodule

bind size_class_free_list_allocator_unit scfl_chk u_scfl_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire
